// ===== rtl/core/skt_pkg.sv =====
// shared types and constants of the sorted key table
`timescale 1ns / 1ps

package skt_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned OUT_W    = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2
  } skt_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } skt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_RESP
  } skt_state_e;

  typedef struct packed {
    logic [CNT_W-1:0]    entry_count;
    logic [POS_W-1:0]    position;
    logic [STATUS_W-1:0] status;
  } skt_result_t;

endpackage

// ===== rtl/core/skt_key_mem.sv =====
// key storage: one write port, one read port with registered read data
`timescale 1ns / 1ps

module skt_key_mem #(
  parameter int unsigned Depth    = 64,
  parameter int unsigned KeyWidth = 32,
  localparam int unsigned AddrW   = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output logic [KeyWidth-1:0] rdata_o,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic [KeyWidth-1:0] wdata_i
);

  logic [KeyWidth-1:0] mem [Depth];
  logic [KeyWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/skt_ctrl.sv =====
// command sequencer: upward scan with insert and remove shifting in one pass
`timescale 1ns / 1ps

module skt_ctrl #(
  parameter int unsigned Depth    = 64,
  parameter int unsigned KeyWidth = 32,
  localparam int unsigned AddrW   = $clog2(Depth),
  localparam int unsigned CntW    = $clog2(Depth + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  logic [skt_pkg::CMD_W-1:0] cmd_i,
  input  logic [KeyWidth-1:0]      key_i,
  input  logic                     cmp_signed_i,
  output logic                     mem_re_o,
  output logic [AddrW-1:0]         mem_raddr_o,
  input  logic [KeyWidth-1:0]      mem_rdata_i,
  output logic                     mem_we_o,
  output logic [AddrW-1:0]         mem_waddr_o,
  output logic [KeyWidth-1:0]      mem_wdata_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output skt_pkg::skt_result_t     res_o
);

  localparam logic [KeyWidth-1:0] SignBit = KeyWidth'(1) << (KeyWidth - 1);
  localparam logic [CntW-1:0]     Full    = CntW'(Depth);

  skt_pkg::skt_state_e  state_q, state_d;
  logic [skt_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [KeyWidth-1:0]  key_q, key_d;
  logic [KeyWidth-1:0]  carry_q, carry_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      ra_q, ra_d;
  logic                 rvalid_q, rvalid_d;
  logic [AddrW-1:0]     ridx_q, ridx_d;
  logic                 found_q, found_d;
  logic [AddrW-1:0]     pos_q, pos_d;
  skt_pkg::skt_status_e status_q, status_d;

  logic [KeyWidth-1:0] key_ov, data_ov;
  logic                key_lt, key_eq, issue, accept, scan_end, scan_stop;
  logic [31:0]         pos_ext, cnt_ext;

  assign accept  = cmd_valid_i && cmd_ready_o;
  assign key_ov  = key_q ^ (cmp_signed_i ? SignBit : '0);
  assign data_ov = mem_rdata_i ^ (cmp_signed_i ? SignBit : '0);
  assign key_lt  = key_ov < data_ov;
  assign key_eq  = key_ov == data_ov;
  assign issue   = (state_q == skt_pkg::S_SCAN) && (ra_q < count_q);
  assign scan_end = (ra_q == count_q) && !rvalid_q;

  // find and remove stop early at a larger key, find also at an equal key
  always_comb begin
    scan_stop = 1'b0;
    if (rvalid_q && !found_q) begin
      unique case (cmd_q)
        skt_pkg::CMD_FIND:   scan_stop = key_lt || key_eq;
        skt_pkg::CMD_REMOVE: scan_stop = key_lt;
        default:             scan_stop = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skt_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd_i == skt_pkg::CMD_INSERT && count_q == Full) begin
            state_d = skt_pkg::S_RESP;
          end else if (cmd_i == skt_pkg::CMD_INSERT || cmd_i == skt_pkg::CMD_FIND ||
                       cmd_i == skt_pkg::CMD_REMOVE) begin
            state_d = skt_pkg::S_SCAN;
          end else begin
            state_d = skt_pkg::S_RESP;
          end
        end
      end
      skt_pkg::S_SCAN: begin
        if (scan_stop || scan_end) begin
          state_d = skt_pkg::S_FINISH;
        end
      end
      skt_pkg::S_FINISH: state_d = skt_pkg::S_RESP;
      skt_pkg::S_RESP: begin
        if (res_ready_i) begin
          state_d = skt_pkg::S_IDLE;
        end
      end
      default: state_d = skt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    key_d       = key_q;
    carry_d     = carry_q;
    count_d     = count_q;
    ra_d        = ra_q;
    rvalid_d    = 1'b0;
    ridx_d      = ridx_q;
    found_d     = found_q;
    pos_d       = pos_q;
    status_d    = status_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = ra_q[AddrW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = ridx_q;
    mem_wdata_o = carry_q;
    unique case (state_q)
      skt_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          key_d    = key_i;
          ra_d     = '0;
          found_d  = 1'b0;
          pos_d    = '0;
          status_d = (cmd_i == skt_pkg::CMD_INSERT && count_q == Full) ?
                     skt_pkg::ST_FULL : skt_pkg::ST_NOT_FOUND;
        end
      end
      skt_pkg::S_SCAN: begin
        if (issue) begin
          mem_re_o = 1'b1;
          ra_d     = ra_q + 1'b1;
          rvalid_d = 1'b1;
          ridx_d   = ra_q[AddrW-1:0];
        end
        if (rvalid_q) begin
          unique case (cmd_q)
            skt_pkg::CMD_INSERT: begin
              carry_d = mem_rdata_i;
              if (found_q) begin
                mem_we_o = 1'b1;
              end else if (key_lt || key_eq) begin
                found_d     = 1'b1;
                pos_d       = ridx_q;
                mem_we_o    = 1'b1;
                mem_wdata_o = key_q;
              end else begin
                carry_d = carry_q;
              end
            end
            skt_pkg::CMD_FIND: begin
              if (!found_q && key_eq) begin
                found_d = 1'b1;
                pos_d   = ridx_q;
              end
            end
            skt_pkg::CMD_REMOVE: begin
              if (found_q) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = ridx_q - 1'b1;
                mem_wdata_o = mem_rdata_i;
              end else if (key_eq) begin
                found_d = 1'b1;
                pos_d   = ridx_q;
              end
            end
            default: ;
          endcase
        end
      end
      skt_pkg::S_FINISH: begin
        unique case (cmd_q)
          skt_pkg::CMD_INSERT: begin
            mem_we_o    = 1'b1;
            mem_waddr_o = count_q[AddrW-1:0];
            mem_wdata_o = found_q ? carry_q : key_q;
            if (!found_q) begin
              pos_d = count_q[AddrW-1:0];
            end
            count_d  = count_q + 1'b1;
            status_d = skt_pkg::ST_OK;
          end
          skt_pkg::CMD_FIND: begin
            if (found_q) begin
              status_d = skt_pkg::ST_OK;
            end
          end
          skt_pkg::CMD_REMOVE: begin
            if (found_q) begin
              count_d  = count_q - 1'b1;
              status_d = skt_pkg::ST_OK;
            end
          end
          default: ;
        endcase
      end
      skt_pkg::S_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= skt_pkg::S_IDLE;
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    carry_q  <= carry_d;
    ra_q     <= ra_d;
    ridx_q   <= ridx_d;
    found_q  <= found_d;
    pos_q    <= pos_d;
    status_q <= status_d;
  end

  assign pos_ext = 32'(pos_q);
  assign cnt_ext = 32'(count_q);

  assign cmd_ready_o       = (state_q == skt_pkg::S_IDLE);
  assign res_valid_o       = (state_q == skt_pkg::S_RESP);
  assign res_o.status      = status_q;
  assign res_o.position    = pos_ext[skt_pkg::POS_W-1:0];
  assign res_o.entry_count = cnt_ext[skt_pkg::CNT_W-1:0];

endmodule

// ===== rtl/core/sorted_key_table_unit.sv =====
// sorted key table top level: apb register, sequencer, key memory, output register
// a find of a key early in the table and a find or remove of an absent key can end the
//   scan before it reaches the last entry
// throughput: one command at a time, bounded by the single memory read port that
//   the scan walks one entry per cycle
// reset: the table is empty and keys compare unsigned; memory contents are not cleared
`timescale 1ns / 1ps

module sorted_key_table_unit #(
  parameter int unsigned TableDepth = 64,
  parameter int unsigned KeyWidth   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [skt_pkg::KEY_W-1:0]   s_axis_tdata,  // key
  input  logic [skt_pkg::CMD_W-1:0]   s_axis_tuser,  // command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [skt_pkg::OUT_W-1:0]   m_axis_tdata,  // status, position, entry_count, pad
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned AddrW = $clog2(TableDepth);

  logic                 cmp_signed_q;
  logic                 mem_re, mem_we;
  logic [AddrW-1:0]     mem_raddr, mem_waddr;
  logic [KeyWidth-1:0]  mem_rdata, mem_wdata;
  logic                 res_valid, res_ready;
  skt_pkg::skt_result_t res;
  logic                 m_valid_q;
  skt_pkg::skt_result_t m_data_q;

  assign pready = 1'b1;
  assign prdata = {31'd0, cmp_signed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_signed_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      cmp_signed_q <= pwdata[0];
    end
  end

  skt_ctrl #(
    .Depth    (TableDepth),
    .KeyWidth (KeyWidth)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_o  (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .key_i        (KeyWidth'(s_axis_tdata)),
    .cmp_signed_i (cmp_signed_q),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  skt_key_mem #(
    .Depth    (TableDepth),
    .KeyWidth (KeyWidth)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q};

endmodule
